// ===== hdl/aad_pkg.sv =====
// Shared types and constants for the ambient auto dimmer.
`timescale 1ns / 1ps
`default_nettype none

package aad_pkg;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_SET    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_AUTO_ENABLE = 3'd0,
    CFG_LOW_CODE    = 3'd1,
    CFG_HIGH_CODE   = 3'd2,
    CFG_OUT_MIN     = 3'd3,
    CFG_OUT_MAX     = 3'd4,
    CFG_INTERVAL_MS = 3'd5,
    CFG_MIN_STEP    = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_t;

  localparam int CODE_W  = 12;  // sample, thresholds and average
  localparam int LEVEL_W = 8;
  localparam int TICK_W  = 16;
  localparam int CFG_W   = 16;
  localparam int DIVD_W  = 20;  // shared divider dividend / quotient
  localparam int STEP_W  = 5;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Reset values of the configuration registers
  localparam logic [CODE_W-1:0]  RST_LOW_CODE    = 12'd0;
  localparam logic [CODE_W-1:0]  RST_HIGH_CODE   = 12'd4095;
  localparam logic [LEVEL_W-1:0] RST_OUT_MIN     = 8'd0;
  localparam logic [LEVEL_W-1:0] RST_OUT_MAX     = 8'd255;
  localparam logic [TICK_W-1:0]  RST_INTERVAL_MS = 16'd100;
  localparam logic [LEVEL_W-1:0] RST_MIN_STEP    = 8'd5;
  localparam logic [LEVEL_W-1:0] RST_LEVEL       = 8'd255;
  localparam logic [TICK_W-1:0]  TICK_SAT        = 16'hFFFF;

endpackage

`default_nettype wire

// ===== hdl/ambient_auto_dimmer.sv =====
// Ambient-light auto dimmer: tick counter, sample averaging and level mapping.
// Ticks, samples that do not end a batch, and unused requests are handled in S_IDLE.
// A set request goes to S_EMIT, which registers the result once the output is free.
// A batch-ending sample divides the sum on the shared divider (20 steps); a clamped level
// then passes S_MAP, S_CMP and S_EMIT, a mapped one S_MAP, S_MUL, 20 more divider steps,
// S_FIX, S_CMP and S_EMIT. in_tready stays low until the result is registered. Sync reset.
`timescale 1ns / 1ps
`default_nettype none

module ambient_auto_dimmer
  import aad_pkg::*;
#(
  parameter int NUM_SAMPLES = 16,
  parameter int ADC_BITS    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: sample [11:0], level [19:12], zero [23:20]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func [1:0]
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: level_res [7:0], changed [8], average [20:9], zero [23:21]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int SUM_W  = CODE_W + $clog2(NUM_SAMPLES);
  localparam int CNT_W  = $clog2(NUM_SAMPLES + 1);
  localparam int MASK_B = (ADC_BITS < CODE_W) ? ADC_BITS : CODE_W;
  localparam logic [CODE_W-1:0] SMP_MASK = CODE_W'((33'd1 << MASK_B) - 33'd1);
  localparam logic [CNT_W-1:0]  BATCH    = CNT_W'(NUM_SAMPLES);
  localparam logic [CODE_W-1:0] BATCH_DEN = CODE_W'(NUM_SAMPLES);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVD_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MAP, S_MUL, S_FIX, S_CMP, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic                auto_en_r;
  logic [CODE_W-1:0]   low_code_r, high_code_r;
  logic [LEVEL_W-1:0]  out_min_r, out_max_r, min_step_r;
  logic [TICK_W-1:0]   interval_r;

  // dimmer state
  logic [TICK_W-1:0]   tick_cnt_r;
  logic                collecting_r;
  logic [CNT_W-1:0]    smp_cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [LEVEL_W-1:0]  cur_level_r;

  // shared divider and sequencer datapath
  logic [CODE_W-1:0]   rem_r;
  logic [DIVD_W-1:0]   quo_r;
  logic [CODE_W-1:0]   den_r;
  logic [STEP_W-1:0]   step_r;
  logic                map_phase_r;
  logic [CODE_W-1:0]   avg_r;
  logic                neg_r;
  logic [LEVEL_W-1:0]  new_level_r;

  // finished result and output register
  logic [LEVEL_W-1:0]  res_level_r;
  logic                res_chg_r;
  logic [CODE_W-1:0]   res_avg_r;
  logic                out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // input decode
  func_t               in_func;
  logic [CODE_W-1:0]   in_smp;
  logic [LEVEL_W-1:0]  in_level;
  logic                in_acc;

  assign in_func  = func_t'(in_tuser);
  assign in_smp   = in_tdata[CODE_W-1:0] & SMP_MASK;
  assign in_level = in_tdata[CODE_W+LEVEL_W-1:CODE_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  // tick path
  logic [TICK_W-1:0] tick_inc, tick_lim;
  assign tick_inc = (tick_cnt_r < TICK_SAT) ? tick_cnt_r + TICK_W'(1) : tick_cnt_r;
  assign tick_lim = (interval_r == '0) ? TICK_W'(1) : interval_r;

  // sample path
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_inc;
  assign sum_add = sum_r + SUM_W'(in_smp);
  assign cnt_inc = smp_cnt_r + CNT_W'(1);

  // divider step: shift one dividend bit into the remainder, subtract if it fits
  logic [CODE_W:0]   div_shift;
  logic              div_fit;
  logic [CODE_W-1:0] rem_nxt;
  assign div_shift = {rem_r, quo_r[DIVD_W-1]};
  assign div_fit   = (div_shift >= {1'b0, den_r});
  assign rem_nxt   = div_fit ? CODE_W'(div_shift - {1'b0, den_r}) : div_shift[CODE_W-1:0];

  // map arithmetic
  logic              span_neg;
  logic [LEVEL_W-1:0] span_mag;
  logic [CODE_W-1:0] avg_off;
  logic [CODE_W-1:0] thr_span;
  logic [DIVD_W-1:0] map_prod;
  assign span_neg = (out_max_r < out_min_r);
  assign span_mag = span_neg ? out_min_r - out_max_r : out_max_r - out_min_r;
  assign avg_off  = avg_r - low_code_r;
  assign thr_span = high_code_r - low_code_r;
  assign map_prod = DIVD_W'(avg_off) * DIVD_W'(span_mag);

  logic [LEVEL_W-1:0] lvl_diff;
  assign lvl_diff = (new_level_r > cur_level_r) ? new_level_r - cur_level_r
                                                : cur_level_r - new_level_r;

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      auto_en_r    <= 1'b1;
      low_code_r   <= RST_LOW_CODE;
      high_code_r  <= RST_HIGH_CODE;
      out_min_r    <= RST_OUT_MIN;
      out_max_r    <= RST_OUT_MAX;
      interval_r   <= RST_INTERVAL_MS;
      min_step_r   <= RST_MIN_STEP;
      tick_cnt_r   <= '0;
      collecting_r <= 1'b0;
      smp_cnt_r    <= '0;
      sum_r        <= '0;
      cur_level_r  <= RST_LEVEL;
      out_tvalid_r <= 1'b0;
      map_phase_r  <= 1'b0;
      step_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_AUTO_ENABLE: auto_en_r   <= cfg_data[0];
          CFG_LOW_CODE:    low_code_r  <= cfg_data[CODE_W-1:0];
          CFG_HIGH_CODE:   high_code_r <= cfg_data[CODE_W-1:0];
          CFG_OUT_MIN:     out_min_r   <= cfg_data[LEVEL_W-1:0];
          CFG_OUT_MAX:     out_max_r   <= cfg_data[LEVEL_W-1:0];
          CFG_INTERVAL_MS: interval_r  <= cfg_data[TICK_W-1:0];
          CFG_MIN_STEP:    min_step_r  <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end

      // load a finished result when the register is free, else drop the taken one
      if (state_r == S_EMIT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_func)
              FUNC_SET: begin
                cur_level_r <= in_level;
                res_level_r <= in_level;
                res_chg_r   <= 1'b1;
                res_avg_r   <= '0;
                state_r     <= S_EMIT;
              end
              FUNC_TICK: begin
                if (auto_en_r && !collecting_r) begin
                  if (tick_inc >= tick_lim) begin
                    tick_cnt_r   <= '0;
                    collecting_r <= 1'b1;
                    smp_cnt_r    <= '0;
                    sum_r        <= '0;
                  end else begin
                    tick_cnt_r <= tick_inc;
                  end
                end
              end
              FUNC_SAMPLE: begin
                if (auto_en_r && collecting_r) begin
                  if (cnt_inc == BATCH) begin
                    // batch complete: divide the sum by the batch length
                    collecting_r <= 1'b0;
                    smp_cnt_r    <= '0;
                    sum_r        <= '0;
                    quo_r        <= DIVD_W'(sum_add);
                    den_r        <= BATCH_DEN;
                    rem_r        <= '0;
                    step_r       <= '0;
                    map_phase_r  <= 1'b0;
                    state_r      <= S_DIV;
                  end else begin
                    sum_r     <= sum_add;
                    smp_cnt_r <= cnt_inc;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= {quo_r[DIVD_W-2:0], div_fit};
          step_r <= step_r + STEP_W'(1);
          if (step_r == LAST_STEP) begin
            state_r <= map_phase_r ? S_FIX : S_MAP;
          end
        end

        S_MAP: begin
          avg_r <= quo_r[CODE_W-1:0];
          priority if (quo_r[CODE_W-1:0] <= low_code_r) begin
            new_level_r <= out_min_r;
            state_r     <= S_CMP;
          end else if (quo_r[CODE_W-1:0] >= high_code_r) begin
            new_level_r <= out_max_r;
            state_r     <= S_CMP;
          end else begin
            state_r <= S_MUL;
          end
        end

        S_MUL: begin
          quo_r       <= map_prod;
          den_r       <= thr_span;
          rem_r       <= '0;
          step_r      <= '0;
          neg_r       <= span_neg;
          map_phase_r <= 1'b1;
          state_r     <= S_DIV;
        end

        S_FIX: begin
          // floor toward minus infinity when the span is reversed
          if (neg_r) begin
            new_level_r <= out_min_r - quo_r[LEVEL_W-1:0]
                           - LEVEL_W'(rem_r != '0);
          end else begin
            new_level_r <= out_min_r + quo_r[LEVEL_W-1:0];
          end
          state_r <= S_CMP;
        end

        S_CMP: begin
          res_avg_r <= avg_r;
          if (lvl_diff >= min_step_r) begin
            cur_level_r <= new_level_r;
            res_level_r <= new_level_r;
            res_chg_r   <= 1'b1;
          end else begin
            res_level_r <= cur_level_r;
            res_chg_r   <= 1'b0;
          end
          state_r <= S_EMIT;
        end

        S_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            out_tdata_r  <= {3'b000, res_avg_r, res_chg_r, res_level_r};
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ===== sim/aad_level_checker.sv =====
// Checker for the ambient auto dimmer: tracks dimmer state and compares every result.
`timescale 1ns / 1ps

module aad_level_checker
  import aad_pkg::*;
#(
  parameter int NUM_SAMPLES = 16,
  parameter int ADC_BITS    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: sample [11:0], level [19:12], zero [23:20]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func [1:0]
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  // out_tdata: level_res [7:0], changed [8], average [20:9], zero [23:21]
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output int                         outstanding,
  output int                         errors
);

  localparam int BATCH = (NUM_SAMPLES < 1) ? 1 : ((NUM_SAMPLES > 256) ? 256 : NUM_SAMPLES);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               changed;
    logic [CODE_W-1:0]  average;
  } dim_result_t;

  dim_result_t dim_results_q[$];

  // configuration copy
  logic               auto_en;
  logic [CODE_W-1:0]  low_c, high_c;
  logic [LEVEL_W-1:0] lvl_min, lvl_max, min_delta;
  logic [TICK_W-1:0]  interval;

  // dimmer state
  logic [TICK_W-1:0]  ticks;
  logic               gathering;
  logic [8:0]         n_samples;
  logic [DIVD_W-1:0]  acc;
  logic [LEVEL_W-1:0] cur_level;

  int waiting    = 0;
  int mismatches = 0;

  assign outstanding = waiting;
  assign errors      = mismatches;

  function automatic logic [LEVEL_W-1:0] map_to_level(input logic [CODE_W-1:0] avg);
    int num, den, q;
    if (avg <= low_c) return lvl_min;
    if (avg >= high_c) return lvl_max;
    num = (int'(avg) - int'(low_c)) * (int'(lvl_max) - int'(lvl_min));
    den = int'(high_c) - int'(low_c);
    q = num / den;
    // floor, not truncation, when out_max is below out_min
    if ((num % den) != 0 && num < 0) q -= 1;
    return LEVEL_W'(int'(lvl_min) + q);
  endfunction

  task automatic advance_dimmer(input func_t f, input logic [CODE_W-1:0] smp_raw,
                                input logic [LEVEL_W-1:0] lvl);
    logic [CODE_W-1:0]  smp, avg;
    logic [LEVEL_W-1:0] nl, diff;
    logic [TICK_W-1:0]  lim;
    logic               chg;
    smp = smp_raw & CODE_W'((1 << ADC_BITS) - 1);
    case (f)
      FUNC_SET: begin
        cur_level = lvl;
        dim_results_q.push_back('{lvl, 1'b1, '0});
      end
      FUNC_TICK: begin
        if (auto_en && !gathering) begin
          lim = (interval == '0) ? TICK_W'(1) : interval;
          if (ticks != TICK_SAT) ticks++;
          if (ticks >= lim) begin
            ticks = '0;
            gathering = 1'b1;
            n_samples = '0;
            acc = '0;
          end
        end
      end
      FUNC_SAMPLE: begin
        if (auto_en && gathering) begin
          acc += smp;
          n_samples++;
          if (n_samples >= BATCH) begin
            avg = CODE_W'(acc / BATCH);
            gathering = 1'b0;
            n_samples = '0;
            acc = '0;
            nl = map_to_level(avg);
            diff = (nl > cur_level) ? nl - cur_level : cur_level - nl;
            chg = (diff >= min_delta);
            if (chg) cur_level = nl;
            dim_results_q.push_back('{cur_level, chg, avg});
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      auto_en   = 1'b1;
      low_c     = RST_LOW_CODE;
      high_c    = RST_HIGH_CODE;
      lvl_min   = RST_OUT_MIN;
      lvl_max   = RST_OUT_MAX;
      interval  = RST_INTERVAL_MS;
      min_delta = RST_MIN_STEP;
      ticks     = '0;
      gathering = 1'b0;
      n_samples = '0;
      acc       = '0;
      cur_level = RST_LEVEL;
      dim_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AUTO_ENABLE: auto_en   = cfg_data[0];
          CFG_LOW_CODE:    low_c     = cfg_data[CODE_W-1:0];
          CFG_HIGH_CODE:   high_c    = cfg_data[CODE_W-1:0];
          CFG_OUT_MIN:     lvl_min   = cfg_data[LEVEL_W-1:0];
          CFG_OUT_MAX:     lvl_max   = cfg_data[LEVEL_W-1:0];
          CFG_INTERVAL_MS: interval  = cfg_data[TICK_W-1:0];
          CFG_MIN_STEP:    min_delta = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      // compare before taking the new request: a result never leaves in its own cycle
      if (out_tvalid && out_tready) begin
        if (dim_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: level %0d changed %0d average %0d",
                     out_tdata[7:0], out_tdata[8], out_tdata[20:9]);
        end else begin
          dim_result_t exp_r;
          exp_r = dim_results_q.pop_front();
          if (out_tdata[7:0] !== exp_r.level || out_tdata[8] !== exp_r.changed ||
              out_tdata[20:9] !== exp_r.average) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: level %0d/%0d changed %0d/%0d average %0d/%0d (exp/got)",
                       exp_r.level, out_tdata[7:0], exp_r.changed, out_tdata[8],
                       exp_r.average, out_tdata[20:9]);
          end
        end
      end
      if (in_tvalid && in_tready)
        advance_dimmer(func_t'(in_tuser), in_tdata[11:0], in_tdata[19:12]);
    end
    waiting <= dim_results_q.size();
  end

endmodule

// ===== sim/tb_ambient_auto_dimmer.sv =====
// Testbench top for the ambient auto dimmer: clock, reset, requests, configuration and verdict.
`timescale 1ns / 1ps

module tb_ambient_auto_dimmer;
  import aad_pkg::*;

  localparam int NUM_SAMPLES  = 16;
  localparam int ADC_BITS     = 12;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_GAP   = 60;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 140;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [2:0]            cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  int outstanding;
  int errors;
  int cycle_cnt   = 0;
  int sent_cnt    = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  ambient_auto_dimmer #(.NUM_SAMPLES(NUM_SAMPLES), .ADC_BITS(ADC_BITS)) dut (
    .clk, .rst_n, .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tvalid, .out_tready, .cfg_we, .cfg_index, .cfg_data
  );

  aad_level_checker #(.NUM_SAMPLES(NUM_SAMPLES), .ADC_BITS(ADC_BITS)) dimmer_chk (
    .clk, .rst_n, .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tvalid, .out_tready, .cfg_we, .cfg_index, .cfg_data,
    .outstanding, .errors
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_req(input func_t f, input logic [CODE_W-1:0] smp,
                          input logic [LEVEL_W-1:0] lvl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {4'd0, lvl, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
  endtask

  // hold off until every result is back, then let a busy divider finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ticks to open a batch, then samples clustered around base
  task automatic send_batch(input int n_ticks, input int base, input int spread,
                            input int n_smp);
    int k, v;
    for (k = 0; k < n_ticks; k++)
      send_req(FUNC_TICK, CODE_W'($urandom), LEVEL_W'($urandom));
    for (k = 0; k < n_smp; k++) begin
      if ($urandom_range(9) == 0) begin
        v = $urandom_range(4095);
      end else begin
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      send_req(FUNC_SAMPLE, CODE_W'(v), LEVEL_W'($urandom));
    end
  endtask

  initial begin
    int ph, r, k, target, n_ticks, lo, hi, b_lo, b_hi, base;
    logic               en;
    logic [LEVEL_W-1:0] mn, mx, stp;
    logic [TICK_W-1:0]  intv;
    bit                 held;

    held = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of the set level, an unused request, a stray sample and a tick
    tx_idle_pct = 19;
    rx_idle_pct = 67;
    send_req(FUNC_SET, 12'hFFF, 8'h00);
    send_req(FUNC_SET, 12'h000, 8'hFF);
    send_req(FUNC_NONE, 12'hFFF, 8'hFF);
    send_req(FUNC_SAMPLE, 12'hFFF, 8'h00);
    send_req(FUNC_TICK, 12'h000, 8'h00);
    wait_idle();
    // zero interval and zero step, a write to the unused index, then one batch
    write_reg(CFG_INTERVAL_MS, 16'd0);
    write_reg(CFG_MIN_STEP, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_req(FUNC_TICK, 12'h000, 8'h00);
    for (k = 0; k < NUM_SAMPLES; k++)
      send_req(FUNC_SAMPLE, k[0] ? 12'hFFF : 12'h000, 8'h00);
    send_req(FUNC_SET, 12'h000, 8'd128);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph < NUM_PHASES / 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 67;
      end else if (ph < 2 * NUM_PHASES / 3) begin
        tx_idle_pct = 67;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      en   = 1'b1;
      lo   = $urandom_range(4095);
      hi   = $urandom_range(4095);
      mn   = LEVEL_W'($urandom);
      mx   = LEVEL_W'($urandom);
      stp  = LEVEL_W'($urandom_range(0, 20));
      intv = TICK_W'($urandom_range(0, 6));
      case (ph % 6)
        0: begin
          lo = $urandom_range(100, 3000);
          hi = lo + $urandom_range(200, 4095 - lo);
          mn = 8'd0;
          mx = 8'd255;
        end
        1: begin
          // crossed or equal thresholds
          hi = $urandom_range(0, 2000);
          lo = hi + $urandom_range(0, 2095);
        end
        2: begin
          // reversed outputs at the extremes of both codes
          lo = 0;
          hi = 4095;
          mn = 8'd255;
          mx = 8'd0;
        end
        3: en = 1'b0;
        4: stp = $urandom_range(1) ? 8'd255 : 8'd0;
        default: if (ph == 5) intv = 16'hFFFF;
      endcase
      if (ph == 11) begin
        lo = 4095;
        hi = 4095;
      end

      write_reg(CFG_AUTO_ENABLE, CFG_W'(en));
      write_reg(CFG_LOW_CODE, CFG_W'(lo));
      write_reg(CFG_HIGH_CODE, CFG_W'(hi));
      write_reg(CFG_OUT_MIN, CFG_W'(mn));
      write_reg(CFG_OUT_MAX, CFG_W'(mx));
      write_reg(CFG_INTERVAL_MS, intv);
      write_reg(CFG_MIN_STEP, CFG_W'(stp));

      b_lo = (lo < hi) ? lo : hi;
      b_hi = (lo < hi) ? hi : lo;
      target = sent_cnt + PHASE_ITEMS;
      while (sent_cnt < target) begin
        r = $urandom_range(99);
        if (intv == '0) n_ticks = 1;
        else if (intv > 24) n_ticks = $urandom_range(1, 8);
        else n_ticks = intv;
        base = $urandom_range(1) ? $urandom_range(b_lo, b_hi) : $urandom_range(4095);
        if (r < 72) begin
          send_batch(n_ticks, base, $urandom_range(0, 300), NUM_SAMPLES);
        end else if (r < 78) begin
          send_batch(n_ticks, base, $urandom_range(0, 300), $urandom_range(1, NUM_SAMPLES - 1));
        end else if (r < 88) begin
          send_req(FUNC_SET, CODE_W'($urandom),
                   (r < 80) ? ($urandom_range(1) ? 8'hFF : 8'h00) : LEVEL_W'($urandom));
        end else if (r < 92) begin
          send_req(FUNC_NONE, CODE_W'($urandom), LEVEL_W'($urandom));
        end else if (r < 96) begin
          send_req(FUNC_SAMPLE, CODE_W'($urandom), LEVEL_W'($urandom));
        end else begin
          send_req(FUNC_TICK, CODE_W'($urandom), LEVEL_W'($urandom));
        end
        if (ph == 1 && !held && sent_cnt >= target - PHASE_ITEMS / 2) begin
          wait_idle();
          held = 1'b1;
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
